FILE: rtl/core/mmsw_pkg.sv
`timescale 1ns / 1ps

package mmsw_pkg;

    // Store depth and the widths that follow from it.
    localparam int MAX_SAMPLES = 32;
    localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int SPAN_W   = 12;
    localparam int VCOUNT_W = 9;
    localparam int MEDIAN_W = 17;
    localparam int WINDOW_W = 18;
    localparam int OUT_W    = 64;

    localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(160);

    // Controller states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_SETTLE,
        S_CAND,
        S_CAP,
        S_WALK,
        S_RANK,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic cap;
        logic walk;
        logic next_cand;
        logic result_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic j_done;
        logic i_last;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/core/mmsw_datapath.sv
`timescale 1ns / 1ps

module mmsw_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mmsw_pkg::t_cmd                  i_cmd,
    output mmsw_pkg::t_status               o_status,
    input  logic [mmsw_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                            i_sample_valid,
    input  logic                            i_cfg_valid,
    input  logic [mmsw_pkg::SPAN_W-1:0]     i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [mmsw_pkg::OUT_W-1:0]      o_out_data
);

    localparam int IDX_W = mmsw_pkg::IDX_W;
    localparam int CNT_W = mmsw_pkg::CNT_W;

    logic signed [mmsw_pkg::SAMPLE_W-1:0] r_mem [mmsw_pkg::MAX_SAMPLES];
    logic signed [mmsw_pkg::SAMPLE_W-1:0] r_rd_data;
    logic signed [mmsw_pkg::SAMPLE_W-1:0] r_cand;
    logic signed [mmsw_pkg::SAMPLE_W-1:0] r_lo;
    logic signed [mmsw_pkg::SAMPLE_W-1:0] r_hi;
    logic [IDX_W-1:0]                     r_cmp_idx;
    logic [CNT_W-1:0]                     r_count;
    logic [CNT_W-1:0]                     r_i;
    logic [CNT_W-1:0]                     r_j;
    logic [CNT_W-1:0]                     r_rank;
    logic                                 r_cmp_vld;
    logic                                 r_out_vld;
    logic [mmsw_pkg::SPAN_W-1:0]          r_span;
    logic [mmsw_pkg::OUT_W-1:0]           r_out_data;

    logic                                 full;
    logic                                 store_en;
    logic [IDX_W-1:0]                     rd_addr;
    logic                                 less;
    logic [CNT_W-1:0]                     half;
    logic [CNT_W-1:0]                     n_i;
    logic [CNT_W-1:0]                     n_rank_lo;
    logic signed [mmsw_pkg::MEDIAN_W-1:0] median;
    logic signed [mmsw_pkg::WINDOW_W-1:0] med_ext;
    logic signed [mmsw_pkg::WINDOW_W-1:0] span_x2;
    logic signed [mmsw_pkg::WINDOW_W-1:0] win_low;
    logic signed [mmsw_pkg::WINDOW_W-1:0] win_high;

    function automatic logic signed [mmsw_pkg::MEDIAN_W-1:0] MEDIAN_W_ext(
        input logic signed [mmsw_pkg::SAMPLE_W-1:0] v
    );
        MEDIAN_W_ext = mmsw_pkg::MEDIAN_W'(v);
    endfunction

    // Store control and the read address: the walk index while walking, else the candidate.
    assign full     = (r_count == CNT_W'(mmsw_pkg::MAX_SAMPLES));
    assign store_en = i_cmd.load && i_sample_valid && !full;
    assign rd_addr  = i_cmd.walk ? r_j[IDX_W-1:0] : r_i[IDX_W-1:0];

    // A walked sample ranks below the candidate if smaller, or equal and stored earlier.
    assign less = (r_rd_data < r_cand) ||
                  ((r_rd_data == r_cand) && (r_cmp_idx < r_i[IDX_W-1:0]));

    assign half      = r_count >> 1;
    assign n_i       = r_i + CNT_W'(1);
    assign n_rank_lo = r_rank + CNT_W'(1);

    // Median in 1/32 units: zero if empty, twice the middle for an odd count, sum of the middles otherwise.
    always_comb begin
        if (r_count == '0) begin
            median = '0;
        end else if (r_count[0]) begin
            median = {r_hi, 1'b0};
        end else begin
            median = MEDIAN_W_ext(r_lo) + MEDIAN_W_ext(r_hi);
        end
    end

    // Scale window around the median.
    assign med_ext  = mmsw_pkg::WINDOW_W'(median);
    assign span_x2  = $signed({{(mmsw_pkg::WINDOW_W - mmsw_pkg::SPAN_W - 1){1'b0}},
                               r_span, 1'b0});
    assign win_low  = med_ext - span_x2;
    assign win_high = med_ext + span_x2;

    // Sample store: one write port while loading, one registered read port.
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_mem[r_count[IDX_W-1:0]] <= i_sample;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Candidate, middle values, compare tag and the result payload.
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_j[IDX_W-1:0];
        if (i_cmd.cap) begin
            r_cand <= r_rd_data;
        end
        if (i_cmd.next_cand) begin
            if (r_rank == half) begin
                r_hi <= r_cand;
            end
            if (n_rank_lo == half) begin
                r_lo <= r_cand;
            end
        end
        if (i_cmd.result_load) begin
            r_out_data <= {2'b00, win_high, win_low, median,
                           mmsw_pkg::VCOUNT_W'(r_count)};
        end
    end

    // Counters, rank, configuration and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_rank    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_span    <= mmsw_pkg::SPAN_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_span <= i_cfg_data;
            end
            if (i_cmd.result_load) begin
                r_count <= '0;
                r_i     <= '0;
            end else begin
                if (store_en) begin
                    r_count <= r_count + CNT_W'(1);
                end
                if (i_cmd.next_cand) begin
                    r_i <= n_i;
                end
            end
            if (i_cmd.cap) begin
                r_j <= '0;
            end else if (i_cmd.walk) begin
                r_j <= r_j + CNT_W'(1);
            end
            r_cmp_vld <= i_cmd.walk;
            if (i_cmd.cap) begin
                r_rank <= '0;
            end else if (r_cmp_vld && less) begin
                r_rank <= r_rank + CNT_W'(1);
            end
            if (i_cmd.result_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Status to the controller.
    assign o_status.count_zero = (r_count == '0);
    assign o_status.j_done     = (r_j == r_count);
    assign o_status.i_last     = (n_i == r_count);
    assign o_status.out_free   = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/core/mmsw_ctrl.sv
`timescale 1ns / 1ps

module mmsw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  mmsw_pkg::t_status i_status,
    output mmsw_pkg::t_cmd    o_cmd
);

    mmsw_pkg::t_state r_state;
    mmsw_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmsw_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands. Each candidate is read, captured, ranked by a walk
    // over the store, and then kept if it sits at a middle rank.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mmsw_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = mmsw_pkg::S_SETTLE;
                end
            end
            mmsw_pkg::S_SETTLE: begin
                if (i_status.count_zero) begin
                    n_state = mmsw_pkg::S_DONE;
                end else begin
                    n_state = mmsw_pkg::S_CAND;
                end
            end
            mmsw_pkg::S_CAND: begin
                n_state = mmsw_pkg::S_CAP;
            end
            mmsw_pkg::S_CAP: begin
                o_cmd.cap = 1'b1;
                n_state   = mmsw_pkg::S_WALK;
            end
            mmsw_pkg::S_WALK: begin
                if (!i_status.j_done) begin
                    o_cmd.walk = 1'b1;
                end else begin
                    n_state = mmsw_pkg::S_RANK;
                end
            end
            mmsw_pkg::S_RANK: begin
                o_cmd.next_cand = 1'b1;
                if (i_status.i_last) begin
                    n_state = mmsw_pkg::S_DONE;
                end else begin
                    n_state = mmsw_pkg::S_CAND;
                end
            end
            mmsw_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = mmsw_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = mmsw_pkg::S_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/core/masked_median_scale_window_core.sv
`timescale 1ns / 1ps

// Median of a masked series of temperature samples, with a scale window.
// Input stream: one sample per request; tdata holds the signed sample in 1/16
// degree units, tuser[0] says the sample is present, tlast closes the series.
// Missing samples are skipped; at most 32 present samples are kept per series.
// Output stream: one request per series with the count, the median in 1/32
// degree units and the window median -/+ twice half_span.
// Configuration: a write on the cfg channel sets half_span; it is always ready.
// Throughput: samples load one per cycle while a series is loading. After the
// last sample the store is ranked candidate by candidate, each candidate taking
// a read, a capture, a walk over the n stored samples and a rank check; the
// result request is presented once every candidate is ranked. The single read
// port of the sample store makes this ranking serial. No sample is taken
// meanwhile.
// Stall: the result waits in an output register; the next series may load
// while it waits, and its own result is held back until the register is free.
// Reset (synchronous, active low) empties the store, drops any pending result
// and sets half_span to 160.

module masked_median_scale_window_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_value
    input  logic [0:0]  s_axis_tuser,   // [0] sample_valid
    input  logic        s_axis_tlast,   // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [8:0] valid_count, [25:9] median_value, [43:26] window_low,
    // [61:44] window_high, [63:62] zero
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data      // half_span
);

    mmsw_pkg::t_cmd    cmd;
    mmsw_pkg::t_status status;

    // Configuration writes are taken at once.
    assign o_cfg_ready = 1'b1;

    mmsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mmsw_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_sample       (s_axis_tdata),
        .i_sample_valid (s_axis_tuser[0]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_data     (m_axis_tdata)
    );

endmodule

FILE: rtl/core/mmsw_checker.sv
`timescale 1ns / 1ps

module mmsw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    logic signed [18:0] up_dist;
    logic signed [18:0] dn_dist;

    // Distances from the median to both window edges.
    assign up_dist = 19'($signed(m_axis_tdata[61:44])) - 19'($signed(m_axis_tdata[25:9]));
    assign dn_dist = 19'($signed(m_axis_tdata[25:9])) - 19'($signed(m_axis_tdata[43:26]));

    // A stalled result request holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The window is symmetric about the median, at an even distance.
    a_window_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (up_dist == dn_dist) && (up_dist[0] == 1'b0))
        else $error("window not symmetric about median");

    // The count never exceeds the store depth.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8:0] <= 9'd32))
        else $error("valid count above store depth");

    // An empty series gives a zero median.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[8:0] == 9'd0) |-> (m_axis_tdata[25:9] == 17'd0))
        else $error("empty series with non-zero median");

    // The block stops taking samples once a series has closed.
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("sample taken straight after end of series");

endmodule

bind masked_median_scale_window_core mmsw_checker u_mmsw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
